// ===== hdl/pfa_pkg.sv =====
// Shared types, constants and field codes for the person follow / fall approach controller.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package pfa_pkg;

  // Camera geometry, front sector and resume distance.
  localparam int unsigned FRAME_COLS     = 224;
  localparam int unsigned CENTER_LOW_PX  = 89;
  localparam int unsigned CENTER_HIGH_PX = 134;
  localparam int unsigned SECTOR_MRAD    = 349;
  localparam int unsigned RESUME_DIST_MM = 1000;
  localparam bit          YAW_FLIP       = 1'b0;

  localparam logic [15:0] NO_DIST   = 16'hFFFF;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;
  localparam logic [7:0]  COL_RESET = 8'd160;

  // Yaw datapath widths. The product gain * |2x - W| * 1000 fits in 30 bits.
  localparam int unsigned PX_W        = 8;
  localparam int unsigned NUM_W       = 30;
  localparam int unsigned SUM_W       = NUM_W + 1;
  localparam int unsigned T_W         = SUM_W - 8;
  localparam int unsigned Q_W         = 20;
  localparam int unsigned RECIP_SHIFT = 31;
  localparam int unsigned RECIP_W     = 28;

  // Rounding bias of half the divisor 256 * W, applied before the shift by 8.
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(128 * FRAME_COLS);
  // Reciprocal of W, exact for every dividend below 2**T_W.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FRAME_COLS) - 64'd1) / 64'(FRAME_COLS));

  typedef enum logic [2:0] {
    FUNC_SIGHT = 3'd0,
    FUNC_KIND  = 3'd1,
    FUNC_FALL  = 3'd2,
    FUNC_BEAM  = 3'd3,
    FUNC_TICK  = 3'd4
  } func_e;

  localparam logic [2:0] REG_YAW_GAIN       = 3'd0;
  localparam logic [2:0] REG_YAW_LIMIT      = 3'd1;
  localparam logic [2:0] REG_FOLLOW_SPEED   = 3'd2;
  localparam logic [2:0] REG_APPROACH_SPEED = 3'd3;
  localparam logic [2:0] REG_ARRIVE_DIST    = 3'd4;
  localparam logic [2:0] REG_HALT_DIST      = 3'd5;
  localparam logic [2:0] REG_SIGHT_TIMEOUT  = 3'd6;
  localparam logic [2:0] REG_APPROACH_LIMIT = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [11:0] yaw_gain_q8;
    logic [13:0] yaw_limit_mrad;
    logic [12:0] follow_speed_mm;
    logic [12:0] approach_speed_mm;
    logic [15:0] arrive_dist_mm;
    logic [15:0] halt_dist_mm;
    logic [15:0] sight_timeout_ticks;
    logic [15:0] approach_limit_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    yaw_gain_q8:          12'd307,
    yaw_limit_mrad:       14'd1000,
    follow_speed_mm:      13'd300,
    approach_speed_mm:    13'd150,
    arrive_dist_mm:       16'd500,
    halt_dist_mm:         16'd500,
    sight_timeout_ticks:  16'd20,
    approach_limit_ticks: 16'd100
  };

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] target_x;
    logic               tracking_on;
    logic               fall_flag;
    logic signed [13:0] beam_angle_mrad;
    logic [15:0]        beam_range_mm;
    logic [15:0]        range_floor_mm;
    logic [15:0]        range_ceil_mm;
    logic               last_beam;
  } item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [12:0]        linear_mm;
    logic signed [14:0] angular_mrad;
    logic               arrived_pulse;
    logic               chat_clear_pulse;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/person_follow_fall_approach_ctrl.sv =====
// Top level of the person follow / fall approach controller: stream ports and pipeline control.
// Depends on pfa_pkg, pfa_cfg, pfa_yaw and pfa_mode.
`default_nettype none

// Every accepted request (sighting, detector kind, fall flag, LiDAR beam or tick, chosen
// by s_axis_tuser) yields exactly one result, in order. The block takes one request per
// clock cycle unless a stalled output has filled every stage; a result is presented once
// the request has moved from the input register through the two yaw stages (gain multiply,
// then reciprocal divide) into the result register. All stages collapse bubbles, so a stalled
// output still lets requests fill the empty stages behind it. The eight registers of the
// write port should only be changed while no request is in flight.
module person_follow_fall_approach_ctrl
  import pfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // target_x[15:0], tracking_on[16], fall_flag[17], beam_angle_mrad[31:18],
  // beam_range_mm[47:32], range_floor_mm[63:48], range_ceil_mm[79:64]
  input  wire logic [79:0]           s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]            s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // linear_mm[12:0], angular_mrad[27:13], arrived_pulse[28], chat_clear_pulse[29], zero[31:30]
  output logic [31:0]                m_axis_tdata,
  // cmd_valid[0]
  output logic [0:0]                 m_axis_tuser
);

  cfg_t    cfg;
  item_t   item_in, item_a_q, item_b_q, item_c_q;
  logic    a_v_q, b_v_q, c_v_q, out_v_q;
  logic    en_a, en_b, en_c, en_out;
  logic signed [14:0] yaw_c;
  result_t res_c, res_q;

  assign en_out = !out_v_q || m_axis_tready;
  assign en_c   = !c_v_q || en_out;
  assign en_b   = !b_v_q || en_c;
  assign en_a   = !a_v_q || en_b;

  assign s_axis_tready = en_a;

  assign item_in.func            = s_axis_tuser;
  assign item_in.target_x        = s_axis_tdata[15:0];
  assign item_in.tracking_on     = s_axis_tdata[16];
  assign item_in.fall_flag       = s_axis_tdata[17];
  assign item_in.beam_angle_mrad = s_axis_tdata[31:18];
  assign item_in.beam_range_mm   = s_axis_tdata[47:32];
  assign item_in.range_floor_mm  = s_axis_tdata[63:48];
  assign item_in.range_ceil_mm   = s_axis_tdata[79:64];
  assign item_in.last_beam       = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_q <= s_axis_tvalid;
      end
      if (en_b) begin
        b_v_q <= a_v_q;
      end
      if (en_c) begin
        c_v_q <= b_v_q;
      end
      if (en_out) begin
        out_v_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      item_a_q <= item_in;
    end
    if (en_b) begin
      item_b_q <= item_a_q;
    end
    if (en_c) begin
      item_c_q <= item_b_q;
    end
    if (en_out) begin
      res_q <= res_c;
    end
  end

  pfa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pfa_yaw u_yaw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_a_i (item_a_q),
    .a_move_i (a_v_q && en_b),
    .en_b_i   (en_b),
    .en_c_i   (en_c),
    .yaw_o    (yaw_c)
  );

  pfa_mode u_mode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (c_v_q && en_out),
    .item_i (item_c_q),
    .yaw_i  (yaw_c),
    .res_o  (res_c)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = res_q.cmd_valid;
  assign m_axis_tdata  = {2'b00, res_q.chat_clear_pulse, res_q.arrived_pulse,
                          res_q.angular_mrad, res_q.linear_mm};

endmodule

`default_nettype wire

// ===== hdl/pfa_cfg.sv =====
// Configuration register bank of the controller, written through a plain write port.
// Depends on pfa_pkg for the register indexes, the cfg_t layout and reset values.
`default_nettype none

module pfa_cfg
  import pfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_YAW_GAIN:       cfg_d.yaw_gain_q8          = cfg_data_i[11:0];
        REG_YAW_LIMIT:      cfg_d.yaw_limit_mrad       = cfg_data_i[13:0];
        REG_FOLLOW_SPEED:   cfg_d.follow_speed_mm      = cfg_data_i[12:0];
        REG_APPROACH_SPEED: cfg_d.approach_speed_mm    = cfg_data_i[12:0];
        REG_ARRIVE_DIST:    cfg_d.arrive_dist_mm       = cfg_data_i;
        REG_HALT_DIST:      cfg_d.halt_dist_mm         = cfg_data_i;
        REG_SIGHT_TIMEOUT:  cfg_d.sight_timeout_ticks  = cfg_data_i;
        REG_APPROACH_LIMIT: cfg_d.approach_limit_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/pfa_yaw.sv =====
// Person column register and the two-stage proportional yaw datapath.
// Depends on pfa_pkg; stage enables come from the pipeline control in the top level.
`default_nettype none

module pfa_yaw
  import pfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire item_t              item_a_i,
  input  wire logic               a_move_i,
  input  wire logic               en_b_i,
  input  wire logic               en_c_i,
  output logic signed [14:0]      yaw_o
);

  logic [PX_W-1:0]       col_q, col_d;
  logic [PX_W-1:0]       px_clamp, x_sel, x;
  logic [PX_W:0]         x2;
  logic [PX_W-1:0]       mag;
  logic                  right_a;
  logic [17:0]           mag_k;
  logic [NUM_W-1:0]      prod_a;
  logic [NUM_W-1:0]      prod_q;
  logic                  neg_q;
  logic [SUM_W-1:0]      sum_b;
  logic [T_W-1:0]        t_b;
  logic [T_W+RECIP_W-1:0] quot_full;
  logic [Q_W-1:0]        quot;
  logic [13:0]           mag_sat;
  logic signed [14:0]    yaw_b, yaw_q;
  logic                  is_sight;

  assign is_sight = (item_a_i.func == FUNC_SIGHT);

  // Stage A: the column as it stands for this request, then gain * |2x - W| * 1000.
  always_comb begin
    if (item_a_i.target_x < 0) begin
      px_clamp = '0;
    end else if (item_a_i.target_x > 16'sd0 + $signed(17'(FRAME_COLS))) begin
      px_clamp = PX_W'(FRAME_COLS);
    end else begin
      px_clamp = item_a_i.target_x[PX_W-1:0];
    end
  end

  assign x_sel = is_sight ? px_clamp : col_q;
  assign x     = (x_sel > PX_W'(FRAME_COLS)) ? PX_W'(FRAME_COLS) : x_sel;
  assign x2    = {x, 1'b0};

  always_comb begin
    right_a = (x2 > (PX_W+1)'(FRAME_COLS));
    if (right_a) begin
      mag = PX_W'(x2 - (PX_W+1)'(FRAME_COLS));
    end else begin
      mag = PX_W'((PX_W+1)'(FRAME_COLS) - x2);
    end
    // Inside the center band there is no turn at all.
    if (x >= PX_W'(CENTER_LOW_PX) && x <= PX_W'(CENTER_HIGH_PX)) begin
      mag = '0;
    end
  end

  assign mag_k  = 18'(mag) * 18'd1000;
  assign prod_a = NUM_W'(cfg_i.yaw_gain_q8) * NUM_W'(mag_k);

  assign col_d = (a_move_i && is_sight) ? px_clamp : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= COL_RESET;
    end else begin
      col_q <= col_d;
    end
  end

  // Stage B: round to nearest, divide by 256 * W (shift, reciprocal), clamp, sign.
  assign sum_b     = SUM_W'(prod_q) + ROUND_BIAS;
  assign t_b       = sum_b[SUM_W-1:8];
  assign quot_full = (T_W+RECIP_W)'(t_b) * (T_W+RECIP_W)'(RECIP);
  assign quot      = quot_full[RECIP_SHIFT +: Q_W];
  assign mag_sat   = (quot > Q_W'(cfg_i.yaw_limit_mrad)) ? cfg_i.yaw_limit_mrad : quot[13:0];
  assign yaw_b     = neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      prod_q <= prod_a;
      neg_q  <= right_a ^ YAW_FLIP;
    end
    if (en_c_i) begin
      yaw_q <= yaw_b;
    end
  end

  assign yaw_o = yaw_q;

endmodule

`default_nettype wire

// ===== hdl/pfa_mode.sv =====
// Mode state of the controller: sighting timing, follow halt, fall approach and front distance.
// Depends on pfa_pkg; produces the result of the request in the last pipeline stage.
`default_nettype none

module pfa_mode
  import pfa_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          fire_i,
  input  wire item_t         item_i,
  input  wire logic signed [14:0] yaw_i,
  output result_t            res_o
);

  logic        track_q, track_d;
  logic        seen_q, seen_d;
  logic [15:0] tss_q, tss_d;
  logic        halted_q, halted_d;
  logic        fall_q, fall_d;
  logic        begun_q, begun_d;
  logic        arrived_q, arrived_d;
  logic [15:0] appr_q, appr_d;
  logic [15:0] front_q, front_d;
  logic [15:0] scan_q, scan_d;

  logic        near_arrive, near_halt, near_resume, live;
  logic [14:0] ang_ext, ang_abs;
  logic        beam_hit;
  logic [15:0] scan_min;
  logic        approaching;
  logic [15:0] appr_cur;
  logic        begun_new;
  logic [15:0] tss_inc;

  assign near_arrive = (front_q != NO_DIST) && (front_q <= cfg_i.arrive_dist_mm);
  assign near_halt   = (front_q != NO_DIST) && (front_q <= cfg_i.halt_dist_mm);
  assign near_resume = (front_q != NO_DIST) && (front_q <= 16'(RESUME_DIST_MM));
  assign live        = seen_q && (tss_q <= cfg_i.sight_timeout_ticks);

  assign ang_ext  = {item_i.beam_angle_mrad[13], item_i.beam_angle_mrad};
  assign ang_abs  = item_i.beam_angle_mrad[13] ? (15'd0 - ang_ext) : ang_ext;
  assign beam_hit = (ang_abs <= 15'(SECTOR_MRAD))
                 && (item_i.beam_range_mm >= item_i.range_floor_mm)
                 && (item_i.beam_range_mm <= item_i.range_ceil_mm)
                 && (item_i.beam_range_mm < scan_q);
  assign scan_min = beam_hit ? item_i.beam_range_mm : scan_q;

  // The first tick of a fall approach starts the approach timer from zero.
  assign approaching = fall_q && !arrived_q;
  assign appr_cur    = (approaching && !begun_q) ? 16'd0 : appr_q;
  assign begun_new   = begun_q || approaching;
  assign tss_inc     = (tss_q != TICK_MAX) ? tss_q + 16'd1 : tss_q;

  always_comb begin
    logic done;
    done      = 1'b0;
    track_d   = track_q;
    seen_d    = seen_q;
    tss_d     = tss_q;
    halted_d  = halted_q;
    fall_d    = fall_q;
    begun_d   = begun_q;
    arrived_d = arrived_q;
    appr_d    = appr_q;
    front_d   = front_q;
    scan_d    = scan_q;
    res_o     = '0;
    case (item_i.func)
      FUNC_SIGHT: begin
        tss_d  = '0;
        seen_d = 1'b1;
      end
      FUNC_KIND: begin
        track_d = item_i.tracking_on;
      end
      FUNC_FALL: begin
        if (item_i.fall_flag && !fall_q) begin
          fall_d    = 1'b1;
          begun_d   = 1'b0;
          arrived_d = 1'b0;
        end else if (!item_i.fall_flag && fall_q) begin
          fall_d                 = 1'b0;
          begun_d                = 1'b0;
          arrived_d              = 1'b0;
          res_o.chat_clear_pulse = 1'b1;
        end
      end
      FUNC_BEAM: begin
        if (item_i.last_beam) begin
          front_d = scan_min;
          scan_d  = NO_DIST;
        end else begin
          scan_d = scan_min;
        end
      end
      FUNC_TICK: begin
        if (fall_q) begin
          if (approaching) begin
            if (near_arrive || appr_cur >= cfg_i.approach_limit_ticks) begin
              res_o.cmd_valid     = 1'b1;
              res_o.arrived_pulse = 1'b1;
              arrived_d           = 1'b1;
            end else begin
              res_o.cmd_valid    = 1'b1;
              res_o.linear_mm    = cfg_i.approach_speed_mm;
              res_o.angular_mrad = yaw_i;
            end
          end
        end else begin
          if (halted_q) begin
            if (near_resume) begin
              res_o.cmd_valid = 1'b1;
              done            = 1'b1;
            end else begin
              halted_d = 1'b0;
            end
          end
          if (!done && live && near_halt) begin
            halted_d        = 1'b1;
            res_o.cmd_valid = 1'b1;
            done            = 1'b1;
          end
          if (!done && track_q && seen_q) begin
            if (tss_q > cfg_i.sight_timeout_ticks) begin
              halted_d = 1'b0;
            end else begin
              res_o.cmd_valid    = 1'b1;
              res_o.linear_mm    = cfg_i.follow_speed_mm;
              res_o.angular_mrad = yaw_i;
            end
          end
        end
        tss_d   = tss_inc;
        begun_d = begun_new;
        if (begun_new && appr_cur != TICK_MAX) begin
          appr_d = appr_cur + 16'd1;
        end else begin
          appr_d = appr_cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q   <= 1'b0;
      seen_q    <= 1'b0;
      tss_q     <= '0;
      halted_q  <= 1'b0;
      fall_q    <= 1'b0;
      begun_q   <= 1'b0;
      arrived_q <= 1'b0;
      appr_q    <= '0;
      front_q   <= NO_DIST;
      scan_q    <= NO_DIST;
    end else if (fire_i) begin
      track_q   <= track_d;
      seen_q    <= seen_d;
      tss_q     <= tss_d;
      halted_q  <= halted_d;
      fall_q    <= fall_d;
      begun_q   <= begun_d;
      arrived_q <= arrived_d;
      appr_q    <= appr_d;
      front_q   <= front_d;
      scan_q    <= scan_d;
    end
  end

endmodule

`default_nettype wire

// ===== verif/pfa_cmd_checker.sv =====
// Checker for the person follow / fall approach controller: predicts every command and
// compares it with what the block sends. Depends on pfa_pkg for the types and constants.
`timescale 1ns / 100ps

module pfa_cmd_checker
  import pfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  req_valid_i,
  input  wire logic                  req_ready_i,
  // target_x[15:0], tracking_on[16], fall_flag[17], beam_angle_mrad[31:18],
  // beam_range_mm[47:32], range_floor_mm[63:48], range_ceil_mm[79:64]
  input  wire logic [79:0]           req_data_i,
  // func[2:0]
  input  wire logic [2:0]            req_func_i,
  input  wire logic                  req_last_i,
  input  wire logic                  res_valid_i,
  input  wire logic                  res_ready_i,
  // linear_mm[12:0], angular_mrad[27:13], arrived_pulse[28], chat_clear_pulse[29]
  input  wire logic [31:0]           res_data_i,
  // cmd_valid[0]
  input  wire logic [0:0]            res_user_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  cfg_t        regs;
  bit          track_en, seen_ever, halted, fall_mode, appr_begun, arrived;
  logic [7:0]  col;
  logic [15:0] since_seen, appr_ticks, front_mm, scan_min_mm;

  result_t     cmds_due[$];
  result_t     want, got;
  int          fails;

  function automatic bit near_within(input int unsigned thr);
    return front_mm != NO_DIST && front_mm <= thr;
  endfunction

  function automatic logic signed [14:0] steer_rate();
    int               x, diff;
    longint unsigned  mag, num, q;
    logic signed [14:0] rate;
    bit               neg;
    x = int'(col);
    if (x > int'(FRAME_COLS)) x = int'(FRAME_COLS);
    if (x >= int'(CENTER_LOW_PX) && x <= int'(CENTER_HIGH_PX)) return '0;
    diff = 2 * x - int'(FRAME_COLS);
    mag  = (diff < 0) ? -diff : diff;
    num  = longint'(regs.yaw_gain_q8) * mag * 64'd1000;
    q    = (num + 64'(128 * FRAME_COLS)) / 64'(256 * FRAME_COLS);
    if (q > regs.yaw_limit_mrad) q = regs.yaw_limit_mrad;
    rate = 15'(q);
    neg  = (diff > 0) ^ YAW_FLIP;
    return neg ? -rate : rate;
  endfunction

  function automatic void run_tick(ref result_t r);
    bit live, done;
    if (fall_mode) begin
      if (!arrived) begin
        if (!appr_begun) begin
          appr_begun = 1'b1;
          appr_ticks = '0;
        end
        // Distance is checked first, then the time limit.
        if (near_within(regs.arrive_dist_mm) || appr_ticks >= regs.approach_limit_ticks) begin
          r.cmd_valid     = 1'b1;
          r.arrived_pulse = 1'b1;
          arrived         = 1'b1;
        end else begin
          r.cmd_valid    = 1'b1;
          r.linear_mm    = regs.approach_speed_mm;
          r.angular_mrad = steer_rate();
        end
      end
    end else begin
      live = seen_ever && since_seen <= regs.sight_timeout_ticks;
      done = 1'b0;
      if (halted) begin
        if (near_within(RESUME_DIST_MM)) begin
          r.cmd_valid = 1'b1;
          done        = 1'b1;
        end else begin
          halted = 1'b0;
        end
      end
      if (!done && live && near_within(regs.halt_dist_mm)) begin
        halted      = 1'b1;
        r.cmd_valid = 1'b1;
        done        = 1'b1;
      end
      if (!done && track_en && seen_ever) begin
        if (since_seen > regs.sight_timeout_ticks) begin
          halted = 1'b0;
        end else begin
          r.cmd_valid    = 1'b1;
          r.linear_mm    = regs.follow_speed_mm;
          r.angular_mrad = steer_rate();
        end
      end
    end
    if (since_seen != TICK_MAX) since_seen++;
    if (appr_begun && appr_ticks != TICK_MAX) appr_ticks++;
  endfunction

  // Advances the predicted controller state by one request and returns its command.
  function automatic result_t compute_command(input logic [2:0] f, input logic [79:0] d,
                                              input logic lst);
    result_t     r;
    int          pxi, angi;
    logic [15:0] rng, lo, hi;
    r = '0;
    case (f)
      FUNC_SIGHT: begin
        pxi = int'($signed(d[15:0]));
        if (pxi < 0) pxi = 0;
        if (pxi > int'(FRAME_COLS)) pxi = int'(FRAME_COLS);
        col        = 8'(pxi);
        since_seen = '0;
        seen_ever  = 1'b1;
      end
      FUNC_KIND: track_en = d[16];
      FUNC_FALL: begin
        if (d[17] && !fall_mode) begin
          fall_mode  = 1'b1;
          appr_begun = 1'b0;
          arrived    = 1'b0;
        end else if (!d[17] && fall_mode) begin
          fall_mode          = 1'b0;
          appr_begun         = 1'b0;
          arrived            = 1'b0;
          r.chat_clear_pulse = 1'b1;
        end
      end
      FUNC_BEAM: begin
        angi = int'($signed(d[31:18]));
        if (angi < 0) angi = -angi;
        rng = d[47:32];
        lo  = d[63:48];
        hi  = d[79:64];
        if (angi <= int'(SECTOR_MRAD) && rng >= lo && rng <= hi && rng < scan_min_mm)
          scan_min_mm = rng;
        if (lst) begin
          front_mm    = scan_min_mm;
          scan_min_mm = NO_DIST;
        end
      end
      FUNC_TICK: run_tick(r);
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs        = CFG_RESET;
      track_en    = 1'b0;
      seen_ever   = 1'b0;
      halted      = 1'b0;
      fall_mode   = 1'b0;
      appr_begun  = 1'b0;
      arrived     = 1'b0;
      col         = COL_RESET;
      since_seen  = '0;
      appr_ticks  = '0;
      front_mm    = NO_DIST;
      scan_min_mm = NO_DIST;
      fails       = 0;
      cmds_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_YAW_GAIN:       regs.yaw_gain_q8          = cfg_data_i[11:0];
          REG_YAW_LIMIT:      regs.yaw_limit_mrad       = cfg_data_i[13:0];
          REG_FOLLOW_SPEED:   regs.follow_speed_mm      = cfg_data_i[12:0];
          REG_APPROACH_SPEED: regs.approach_speed_mm    = cfg_data_i[12:0];
          REG_ARRIVE_DIST:    regs.arrive_dist_mm       = cfg_data_i;
          REG_HALT_DIST:      regs.halt_dist_mm         = cfg_data_i;
          REG_SIGHT_TIMEOUT:  regs.sight_timeout_ticks  = cfg_data_i;
          REG_APPROACH_LIMIT: regs.approach_limit_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (cmds_due.size() == 0) begin
          $error("command arrived with no request outstanding");
          fails++;
        end else begin
          want = cmds_due.pop_front();
          got.cmd_valid        = res_user_i[0];
          got.linear_mm        = res_data_i[12:0];
          got.angular_mrad     = res_data_i[27:13];
          got.arrived_pulse    = res_data_i[28];
          got.chat_clear_pulse = res_data_i[29];
          check_field("cmd_valid", want.cmd_valid, got.cmd_valid);
          check_field("linear_mm", want.linear_mm, got.linear_mm);
          check_field("angular_mrad", int'(want.angular_mrad), int'(got.angular_mrad));
          check_field("arrived_pulse", want.arrived_pulse, got.arrived_pulse);
          check_field("chat_clear_pulse", want.chat_clear_pulse, got.chat_clear_pulse);
        end
      end
      if (req_valid_i && req_ready_i)
        cmds_due.push_back(compute_command(req_func_i, req_data_i, req_last_i));
      fail_count_o <= fails;
      pending_o    <= cmds_due.size();
    end
  end

endmodule

// ===== verif/person_follow_fall_approach_ctrl_test.sv =====
// Top of the controller testbench: clock, reset, request stimulus, output stalls and verdict.
// Depends on pfa_pkg, the controller and pfa_cmd_checker.
`timescale 1ns / 100ps

module person_follow_fall_approach_ctrl_test;
  import pfa_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 112;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  s_tvalid   = 1'b0;
  logic [79:0]           s_tdata    = '0;
  logic [2:0]            s_tuser    = '0;
  logic                  s_tlast    = 1'b0;
  logic                  m_tready   = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [31:0]           m_tdata;
  wire  [0:0]            m_tuser;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int hold_cycles  = 0;
  int burst_left   = 0;
  int sent         = 0;

  person_follow_fall_approach_ctrl DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  pfa_cmd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_func_i   (s_tuser),
    .req_last_i   (s_tlast),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .res_user_i   (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial forever #5 clk_i = ~clk_i;

  // Receiver: free-flowing stretches, hard stalls and cycle-by-cycle coin flips.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_tready    <= 1'b1;
          hold_cycles <= $urandom_range(5, 60);
        end
        1: begin
          m_tready    <= 1'b0;
          hold_cycles <= $urandom_range(1, 12);
        end
        default: m_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("person_follow_fall_approach_ctrl_test NOT OK");
    $finish;
  end

  function automatic logic [79:0] noise_bits();
    return 80'({$urandom, $urandom, $urandom});
  endfunction

  // Sends one request; the sender runs in bursts with idle gaps between them.
  task automatic send_req(input logic [2:0] f, input logic [79:0] d, input logic lst);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= d;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    if (f <= FUNC_TICK) sent++;
  endtask

  task automatic wait_idle();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic sight_req(input logic [15:0] px);
    logic [79:0] d;
    d        = noise_bits();
    d[15:0]  = px;
    send_req(FUNC_SIGHT, d, 1'($urandom_range(0, 1)));
  endtask

  task automatic kind_req(input logic on);
    logic [79:0] d;
    d     = noise_bits();
    d[16] = on;
    send_req(FUNC_KIND, d, 1'($urandom_range(0, 1)));
  endtask

  task automatic fall_req(input logic flag);
    logic [79:0] d;
    d     = noise_bits();
    d[17] = flag;
    send_req(FUNC_FALL, d, 1'($urandom_range(0, 1)));
  endtask

  task automatic tick_req();
    send_req(FUNC_TICK, noise_bits(), 1'($urandom_range(0, 1)));
  endtask

  task automatic beam_req(input int ang, input logic [15:0] rng, input logic [15:0] lo,
                          input logic [15:0] hi, input logic lst);
    logic [79:0] d;
    d        = noise_bits();
    d[31:18] = 14'(ang);
    d[47:32] = rng;
    d[63:48] = lo;
    d[79:64] = hi;
    send_req(FUNC_BEAM, d, lst);
  endtask

  function automatic logic [15:0] pick_column();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(86, 137));
      default: return 16'($urandom_range(0, 224));
    endcase
  endfunction

  // A LiDAR scan of a few beams; now and then the closing beam is left out.
  task automatic scan_scene();
    int          n;
    int          ang;
    logic [15:0] lo, hi, rng;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else begin
      lo = 16'($urandom_range(0, 150));
      hi = 16'($urandom_range(3000, 65535));
    end
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    ang = ($urandom_range(0, 1) != 0) ? $urandom_range(349, 350)
                                                   : -int'($urandom_range(349, 350));
        2, 3, 4: ang = int'($signed(14'($urandom)));
        default: ang = int'($urandom_range(0, 700)) - 350;
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: rng = 16'($urandom);
        3:       rng = 16'h0000;
        4:       rng = 16'hFFFF;
        5:       rng = lo;
        6:       rng = hi;
        default: rng = 16'($urandom_range(100, 2500));
      endcase
      beam_req(ang, rng, lo, hi, i == n - 1 && $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic tick_run();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    repeat (n) tick_req();
  endtask

  task automatic noise_req();
    logic [2:0] f;
    if ($urandom_range(0, 1) != 0) f = 3'($urandom_range(int'(FUNC_TICK) + 1, 7));
    else f = 3'($urandom_range(0, 7));
    send_req(f, noise_bits(), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic directed_reqs();
    tick_req();
    kind_req(1'b1);
    // Column clamping at both ends of the signed range, then the centre band edges.
    sight_req(16'h8000);
    tick_req();
    sight_req(16'h7FFF);
    tick_req();
    sight_req(16'd89);
    tick_req();
    sight_req(16'd135);
    tick_req();
    // Sector edge, outside sector and below floor, then the closing beam.
    beam_req(349, 16'd300, 16'd100, 16'd5000, 1'b0);
    beam_req(-350, 16'd200, 16'd0, 16'hFFFF, 1'b0);
    beam_req(0, 16'd50, 16'd100, 16'd5000, 1'b0);
    beam_req(-349, 16'd400, 16'd100, 16'd5000, 1'b1);
    tick_req();
    // Fall entry, repeated level, arrival by distance, silence after, then clear.
    fall_req(1'b1);
    fall_req(1'b1);
    tick_req();
    tick_req();
    fall_req(1'b0);
    fall_req(1'b0);
    // A scan with no qualifying beam leaves nothing seen.
    beam_req(-8192, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    tick_req();
    // The three unused function codes above the tick.
    send_req(3'(int'(FUNC_TICK) + 1), noise_bits(), 1'b1);
    send_req(3'(int'(FUNC_TICK) + 2), noise_bits(), 1'b0);
    send_req(3'(int'(FUNC_TICK) + 3), 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 1'b1);
    kind_req(1'b0);
    tick_req();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] vals [8];
    int                    pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        directed_reqs();
        // The sender holds off here until every command has come back.
        wait_idle();
      end else begin
        wait_idle();
        case (p)
          1: foreach (vals[i]) vals[i] = '0;
          2: foreach (vals[i]) vals[i] = '1;
          3: begin
            vals[REG_YAW_GAIN]       = 16'd4095;
            vals[REG_YAW_LIMIT]      = 16'd10000;
            vals[REG_FOLLOW_SPEED]   = 16'd5000;
            vals[REG_APPROACH_SPEED] = 16'd5000;
            vals[REG_ARRIVE_DIST]    = 16'hFFFF;
            vals[REG_HALT_DIST]      = 16'hFFFF;
            vals[REG_SIGHT_TIMEOUT]  = 16'hFFFF;
            vals[REG_APPROACH_LIMIT] = 16'hFFFF;
          end
          default: begin
            vals[REG_YAW_GAIN]       = 16'($urandom_range(0, 4095));
            vals[REG_YAW_LIMIT]      = 16'($urandom_range(0, 10000));
            vals[REG_FOLLOW_SPEED]   = 16'($urandom_range(0, 5000));
            vals[REG_APPROACH_SPEED] = 16'($urandom_range(0, 5000));
            vals[REG_ARRIVE_DIST]    = 16'($urandom_range(200, 1500));
            vals[REG_HALT_DIST]      = 16'($urandom_range(200, 1500));
            vals[REG_SIGHT_TIMEOUT]  = 16'($urandom_range(0, 40));
            vals[REG_APPROACH_LIMIT] = 16'($urandom_range(0, 30));
          end
        endcase
        write_regs(vals);
      end

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) scan_scene();
        else if (pick < 60) tick_run();
        else if (pick < 75) sight_req(pick_column());
        else if (pick < 82) kind_req($urandom_range(0, 4) != 0);
        else if (pick < 92) fall_req(1'($urandom_range(0, 1)));
        else noise_req();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("person_follow_fall_approach_ctrl_test OK");
    end else begin
      $display("person_follow_fall_approach_ctrl_test NOT OK");
    end
    $finish;
  end

endmodule
